[rtl/buddy_block_allocator_unit_defines.svh]
// ----------------------------------------------------------------------------
// buddy block allocator assertion macros
// shared property wrappers for the port checker
// ----------------------------------------------------------------------------
`ifndef BUDDY_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH
`define BUDDY_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH

// same-cycle implication, reset masks the check
`define BBA_ASSERT_NOW(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error("bba port check failed");

// next-cycle implication
`define BBA_ASSERT_NEXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error("bba port check failed");

`endif

[rtl/bba_pkg.sv]
// ----------------------------------------------------------------------------
// bba_pkg
// widths, status codes and helpers of the buddy block allocator
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int DEF_MAX_ORDER = 10;
  localparam int DEF_ID_BITS   = 16;

  // internal order width: holds orders up to 16 and a rounded request up to 11
  localparam int ORD_W = 5;

  // port field widths
  localparam int CFG_W       = 8;
  localparam int POOL_W      = 4;
  localparam int IN_OWN_W    = 16;
  localparam int IN_REQ_W    = 11;
  localparam int IN_IDX_W    = 10;
  localparam int IN_DATA_W   = 40;
  localparam int OUT_CNT_W   = 11;
  localparam int OUT_OWN_W   = 16;
  localparam int OUT_ORD_W   = 4;
  localparam int OUT_START_W = 10;
  localparam int OUT_DATA_W  = 48;
  localparam int OUT_PAD_W   = OUT_DATA_W - OUT_CNT_W - OUT_OWN_W - OUT_ORD_W - OUT_START_W;

  typedef enum logic [1:0] {
    ST_GRANT     = 2'd0,
    ST_FAIL      = 2'd1,
    ST_READ_OK   = 2'd2,
    ST_BAD_INDEX = 2'd3
  } status_t;

  // smallest k with 2^k >= req, zero request counts as one unit
  function automatic logic [ORD_W-1:0] req_order(input logic [IN_REQ_W-1:0] req);
    logic [IN_REQ_W-1:0] m;
    logic [ORD_W-1:0]    k;
    m = req - IN_REQ_W'(1);
    k = '0;
    if (req > IN_REQ_W'(1)) begin
      for (int b = 0; b < IN_REQ_W; b++) begin
        if (m[b]) k = ORD_W'(b + 1);
      end
    end
    return k;
  endfunction

endpackage

[rtl/bba_ram.sv]
// ----------------------------------------------------------------------------
// bba_ram
// simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module bba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

[rtl/buddy_block_allocator_unit.sv]
// ----------------------------------------------------------------------------
// buddy_block_allocator_unit
// first-fit buddy allocator over an address-ordered block list in ram
// ----------------------------------------------------------------------------
// channel  dir  handshake             payload
// in_      in   in_tvalid/in_tready   tuser: opcode; tdata: owner, request, index
// out_     out  out_tvalid/out_tready tuser: status; tdata: count, owner, order, start
// cfg_     in   cfg_tvalid/cfg_tready tdata: pool_order
//
// an in-range read passes through S_RD_WAIT, a bad index or a zero owner goes
// straight to S_FIN; an allocate reads each scanned entry, moves each tail entry
// and writes the head and one free buddy per split, all through the one ram port pair
// reset and every cfg word rewrite entry 0 in S_INIT, in_tready low meanwhile
// in_tready is high only while the sequencer idles; a result waits in the
// output register and stalls the sequencer only if a second one is ready
// ----------------------------------------------------------------------------
module buddy_block_allocator_unit
  import bba_pkg::*;
#(
  parameter int MAX_ORDER = DEF_MAX_ORDER,
  parameter int ID_BITS   = DEF_ID_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // config: [3:0] pool_order, rest unused
  input  logic                  cfg_tvalid,
  output logic                  cfg_tready,
  input  logic [CFG_W-1:0]      cfg_tdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [15:0] owner_id, [26:16] request_units, [36:27] block_index, rest zero
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // [0] opcode
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [10:0] block_count, [26:11] block_owner, [30:27] block_order,
  // [40:31] block_start, rest zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  // [1:0] status
  output logic [1:0]            out_tuser
);

  localparam int DEPTH   = 1 << MAX_ORDER;
  localparam int IDX_W   = MAX_ORDER;
  localparam int CNT_W   = MAX_ORDER + 1;
  localparam int START_W = MAX_ORDER;
  localparam int ENT_W   = ORD_W + ID_BITS + START_W;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_RD_WAIT, S_SC_RD, S_SC_CK, S_CALC,
    S_MV_RD, S_MV_WR, S_WR_HEAD, S_WR_INS, S_FIN
  } state_t;

  state_t               state_r, state_nxt;
  logic [ORD_W-1:0]     pool_r, pool_nxt;
  logic [CNT_W-1:0]     total_r, total_nxt;
  logic [ID_BITS-1:0]   owner_r, owner_nxt;
  logic [ORD_W-1:0]     k_r, k_nxt;
  logic [IDX_W-1:0]     ptr_r, ptr_nxt;     // scan pointer, then insert address
  logic [IDX_W-1:0]     pos_r, pos_nxt;     // hit position
  logic [IDX_W-1:0]     j_r, j_nxt;         // tail move pointer
  logic [ORD_W-1:0]     ord_r, ord_nxt;
  logic [START_W-1:0]   start_r, start_nxt;
  logic [ORD_W-1:0]     n_r, n_nxt;         // split count
  status_t              res_st_r, res_st_nxt;
  logic [ID_BITS-1:0]   res_own_r, res_own_nxt;
  logic [ORD_W-1:0]     res_ord_r, res_ord_nxt;
  logic [START_W-1:0]   res_start_r, res_start_nxt;
  logic                 out_valid_r, out_valid_nxt;
  status_t              out_st_r, out_st_nxt;
  logic [CNT_W-1:0]     out_cnt_r, out_cnt_nxt;
  logic [ID_BITS-1:0]   out_own_r, out_own_nxt;
  logic [ORD_W-1:0]     out_ord_r, out_ord_nxt;
  logic [START_W-1:0]   out_start_r, out_start_nxt;

  // ram ports
  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr, ram_raddr;
  logic [ENT_W-1:0]     ram_wdata, ram_rdata;
  logic [ORD_W-1:0]     rd_ord;
  logic [ID_BITS-1:0]   rd_own;
  logic [START_W-1:0]   rd_start;

  // input fields
  logic                 in_fire, cfg_fire;
  logic [IN_OWN_W-1:0]  in_owner;
  logic [IN_REQ_W-1:0]  in_req;
  logic [IN_IDX_W-1:0]  in_idx;
  logic [ID_BITS-1:0]   in_owner_m;
  logic [POOL_W-1:0]    cfg_pool;

  // split planning
  logic [ORD_W-1:0]     diff;
  logic [CNT_W-1:0]     room;

  assign in_owner   = in_tdata[IN_OWN_W-1:0];
  assign in_req     = in_tdata[IN_OWN_W +: IN_REQ_W];
  assign in_idx     = in_tdata[IN_OWN_W+IN_REQ_W +: IN_IDX_W];
  assign in_owner_m = ID_BITS'(in_owner);   // masks to id width
  assign cfg_pool   = cfg_tdata[POOL_W-1:0];

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_tready = 1'b1;
  assign in_fire    = in_tvalid && in_tready;
  assign cfg_fire   = cfg_tvalid && cfg_tready;

  assign rd_ord   = ram_rdata[ENT_W-1 -: ORD_W];
  assign rd_own   = ram_rdata[START_W +: ID_BITS];
  assign rd_start = ram_rdata[START_W-1:0];

  assign diff = ord_r - k_r;
  assign room = CNT_W'(DEPTH) - total_r;

  bba_ram #(
    .WIDTH (ENT_W),
    .DEPTH (DEPTH)
  ) u_list (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    pool_nxt      = pool_r;
    total_nxt     = total_r;
    owner_nxt     = owner_r;
    k_nxt         = k_r;
    ptr_nxt       = ptr_r;
    pos_nxt       = pos_r;
    j_nxt         = j_r;
    ord_nxt       = ord_r;
    start_nxt     = start_r;
    n_nxt         = n_r;
    res_st_nxt    = res_st_r;
    res_own_nxt   = res_own_r;
    res_ord_nxt   = res_ord_r;
    res_start_nxt = res_start_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_st_nxt    = out_st_r;
    out_cnt_nxt   = out_cnt_r;
    out_own_nxt   = out_own_r;
    out_ord_nxt   = out_ord_r;
    out_start_nxt = out_start_r;
    ram_we        = 1'b0;
    ram_waddr     = ptr_r;
    ram_wdata     = '0;
    ram_raddr     = ptr_r;

    unique case (state_r)
      // one free block covering the pool
      S_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = {pool_r, {ID_BITS{1'b0}}, {START_W{1'b0}}};
        total_nxt = CNT_W'(1);
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        ram_raddr = IDX_W'(in_idx);
        if (in_fire) begin
          owner_nxt     = in_owner_m;
          k_nxt         = req_order(in_req);
          ptr_nxt       = '0;
          res_own_nxt   = '0;
          res_ord_nxt   = '0;
          res_start_nxt = '0;
          if (in_tuser) begin
            if (32'(in_idx) >= 32'(total_r)) begin
              res_st_nxt = ST_BAD_INDEX;
              state_nxt  = S_FIN;
            end else begin
              state_nxt  = S_RD_WAIT;
            end
          end else if (in_owner_m == '0) begin
            res_st_nxt = ST_FAIL;
            state_nxt  = S_FIN;
          end else begin
            state_nxt  = S_SC_RD;
          end
        end
      end
      S_RD_WAIT: begin
        res_st_nxt    = ST_READ_OK;
        res_own_nxt   = rd_own;
        res_ord_nxt   = rd_ord;
        res_start_nxt = rd_start;
        state_nxt     = S_FIN;
      end
      // first fit scan
      S_SC_RD: begin
        ram_raddr = ptr_r;
        state_nxt = S_SC_CK;
      end
      S_SC_CK: begin
        if (rd_own == '0 && rd_ord >= k_r) begin
          pos_nxt   = ptr_r;
          ord_nxt   = rd_ord;
          start_nxt = rd_start;
          state_nxt = S_CALC;
        end else if (({1'b0, ptr_r} + CNT_W'(1)) == total_r) begin
          res_st_nxt = ST_FAIL;
          state_nxt  = S_FIN;
        end else begin
          ptr_nxt   = ptr_r + IDX_W'(1);
          state_nxt = S_SC_RD;
        end
      end
      // splits are capped by the room left in the list
      S_CALC: begin
        if ({{CNT_W{1'b0}}, diff} < {{ORD_W{1'b0}}, room}) n_nxt = diff;
        else n_nxt = ORD_W'(room);
        j_nxt = IDX_W'(total_r - CNT_W'(1));
        if (n_nxt != '0 && total_r > ({1'b0, pos_r} + CNT_W'(1))) state_nxt = S_MV_RD;
        else state_nxt = S_WR_HEAD;
      end
      // tail moves up by n, from the end down
      S_MV_RD: begin
        ram_raddr = j_r;
        state_nxt = S_MV_WR;
      end
      S_MV_WR: begin
        ram_we    = 1'b1;
        ram_waddr = j_r + IDX_W'(n_r);
        ram_wdata = ram_rdata;
        if (j_r == pos_r + IDX_W'(1)) begin
          state_nxt = S_WR_HEAD;
        end else begin
          j_nxt     = j_r - IDX_W'(1);
          state_nxt = S_MV_RD;
        end
      end
      S_WR_HEAD: begin
        ram_we        = 1'b1;
        ram_waddr     = pos_r;
        ram_wdata     = {ord_r - n_r, owner_r, start_r};
        ord_nxt       = ord_r - n_r;
        ptr_nxt       = pos_r + IDX_W'(1);
        total_nxt     = total_r + CNT_W'(n_r);
        res_st_nxt    = ST_GRANT;
        res_own_nxt   = owner_r;
        res_ord_nxt   = ord_r - n_r;
        res_start_nxt = start_r;
        state_nxt     = (n_r == '0) ? S_FIN : S_WR_INS;
      end
      // free buddies, smallest first
      S_WR_INS: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_r;
        ram_wdata = {ord_r, {ID_BITS{1'b0}}, start_r + (START_W'(1) << ord_r)};
        ord_nxt   = ord_r + ORD_W'(1);
        ptr_nxt   = ptr_r + IDX_W'(1);
        n_nxt     = n_r - ORD_W'(1);
        if (n_r == ORD_W'(1)) state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_st_nxt    = res_st_r;
          out_cnt_nxt   = total_r;
          out_own_nxt   = res_own_r;
          out_ord_nxt   = res_ord_r;
          out_start_nxt = res_start_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_INIT;
    endcase

    // a config word restarts the list
    if (cfg_fire) begin
      if (ORD_W'(cfg_pool) > ORD_W'(MAX_ORDER)) pool_nxt = ORD_W'(MAX_ORDER);
      else pool_nxt = ORD_W'(cfg_pool);
      state_nxt = S_INIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      pool_r      <= (MAX_ORDER < 10) ? ORD_W'(MAX_ORDER) : ORD_W'(10);
      total_r     <= CNT_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pool_r      <= pool_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
    owner_r     <= owner_nxt;
    k_r         <= k_nxt;
    ptr_r       <= ptr_nxt;
    pos_r       <= pos_nxt;
    j_r         <= j_nxt;
    ord_r       <= ord_nxt;
    start_r     <= start_nxt;
    n_r         <= n_nxt;
    res_st_r    <= res_st_nxt;
    res_own_r   <= res_own_nxt;
    res_ord_r   <= res_ord_nxt;
    res_start_r <= res_start_nxt;
    out_st_r    <= out_st_nxt;
    out_cnt_r   <= out_cnt_nxt;
    out_own_r   <= out_own_nxt;
    out_ord_r   <= out_ord_nxt;
    out_start_r <= out_start_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_st_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, OUT_START_W'(out_start_r), OUT_ORD_W'(out_ord_r),
                       OUT_OWN_W'(out_own_r), OUT_CNT_W'(out_cnt_r)};

endmodule

[rtl/bba_chk.sv]
// ----------------------------------------------------------------------------
// bba_chk
// port-level checks of the buddy block allocator, bound to the top level
// ----------------------------------------------------------------------------
`include "buddy_block_allocator_unit_defines.svh"

module bba_chk
  import bba_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [1:0]            out_tuser
);

  // a stalled result word holds
  `BBA_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  // the sequencer is busy right after taking a word
  `BBA_ASSERT_NEXT(a_busy, in_tvalid && in_tready, !in_tready)
  // failures carry no block
  `BBA_ASSERT_NOW(a_fail_zero, out_tvalid && (out_tuser == ST_FAIL || out_tuser == ST_BAD_INDEX), out_tdata[40:11] == '0)
  // a grant always has an owner
  `BBA_ASSERT_NOW(a_grant_owner, out_tvalid && out_tuser == ST_GRANT, out_tdata[26:11] != '0)
  // the list is never empty
  `BBA_ASSERT_NOW(a_count, out_tvalid, out_tdata[10:0] != '0)

endmodule

bind buddy_block_allocator_unit bba_chk u_bba_chk (.*);

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: buddy block allocator testbench
// drives allocate and read words through the stream ports, changes the
// pool order between phases and checks every result word against a
// block-list predictor kept in a small scoreboard class
// ----------------------------------------------------------------------------
module tb_top;
  import bba_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIST_DEPTH  = 1 << DEF_MAX_ORDER;
  localparam int CYCLE_LIMIT = 10000000;
  localparam logic OP_ALLOC  = 1'b0;
  localparam logic OP_READ   = 1'b1;

  // one expected result word
  typedef struct packed {
    status_t                status;
    logic [OUT_CNT_W-1:0]   count;
    logic [OUT_OWN_W-1:0]   owner;
    logic [OUT_ORD_W-1:0]   order;
    logic [OUT_START_W-1:0] start;
  } alloc_result_t;

  // block-list predictor and queue of pending result words
  class alloc_scoreboard;
    logic [3:0]  blk_order [LIST_DEPTH];
    logic [15:0] blk_owner [LIST_DEPTH];
    logic [9:0]  blk_start [LIST_DEPTH];
    int          blk_total;
    int          pool_ord;
    alloc_result_t pending[$];
    int errors;
    int grants, fails, reads, bad_reads;

    function void restart(int ord);
      pool_ord = (ord > DEF_MAX_ORDER) ? DEF_MAX_ORDER : ord;
      foreach (blk_order[i]) begin
        blk_order[i] = '0;
        blk_owner[i] = '0;
        blk_start[i] = '0;
      end
      blk_order[0] = 4'(pool_ord);
      blk_total = 1;
    endfunction

    // work out the result of one accepted word
    function void note_word(logic op, logic [15:0] owner, logic [10:0] req,
                            logic [9:0] idx);
      alloc_result_t r;
      int k, i, hit;
      r = '0;
      if (op == OP_READ) begin
        if (idx >= blk_total) begin
          r.status = ST_BAD_INDEX;
          bad_reads++;
        end else begin
          r.status = ST_READ_OK;
          r.owner  = blk_owner[idx];
          r.order  = blk_order[idx];
          r.start  = blk_start[idx];
          reads++;
        end
      end else begin
        k = 0;
        while (k < 12 && (1 << k) < req) k++;
        hit = -1;
        if (owner != 0) begin
          for (i = 0; i < blk_total; i++) begin
            if (blk_owner[i] == 0 && blk_order[i] >= k) begin
              hit = i;
              break;
            end
          end
        end
        if (hit < 0) begin
          r.status = ST_FAIL;
          fails++;
        end else begin
          // halve until the size fits, upper half goes in right after
          while (blk_order[hit] > k && blk_total < LIST_DEPTH) begin
            for (i = blk_total; i > hit + 1; i--) begin
              blk_order[i] = blk_order[i-1];
              blk_owner[i] = blk_owner[i-1];
              blk_start[i] = blk_start[i-1];
            end
            blk_order[hit]   = blk_order[hit] - 4'd1;
            blk_order[hit+1] = blk_order[hit];
            blk_owner[hit+1] = '0;
            blk_start[hit+1] = blk_start[hit] + 10'(1 << blk_order[hit]);
            blk_total++;
          end
          blk_owner[hit] = owner;
          r.status = ST_GRANT;
          r.owner  = owner;
          r.order  = blk_order[hit];
          r.start  = blk_start[hit];
          grants++;
        end
      end
      r.count = OUT_CNT_W'(blk_total);
      pending.push_back(r);
    endfunction

    function void check_word(logic [1:0] st, logic [OUT_DATA_W-1:0] d);
      alloc_result_t e;
      if (pending.size() == 0) begin
        $error("result word with nothing expected: status %0d data %h", st, d);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (st != e.status) begin
        $error("status: expected %0d actual %0d", e.status, st); errors++;
      end
      if (d[10:0] != e.count) begin
        $error("block_count: expected %0d actual %0d", e.count, d[10:0]); errors++;
      end
      if (d[26:11] != e.owner) begin
        $error("block_owner: expected %h actual %h", e.owner, d[26:11]); errors++;
      end
      if (d[30:27] != e.order) begin
        $error("block_order: expected %0d actual %0d", e.order, d[30:27]); errors++;
      end
      if (d[40:31] != e.start) begin
        $error("block_start: expected %0d actual %0d", e.start, d[40:31]); errors++;
      end
      if (d[47:41] != '0) begin
        $error("pad bits: expected 0 actual %h", d[47:41]); errors++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_tvalid = 1'b0;
  logic                  cfg_tready;
  logic [CFG_W-1:0]      cfg_tdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // [15:0] owner, [26:16] request, [36:27] index
  logic                  in_tuser = 1'b0; // [0] opcode
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;       // [10:0] count, [26:11] owner, [30:27] order,
                                          // [40:31] start
  logic [1:0]            out_tuser;       // [1:0] status

  alloc_scoreboard sb = new();
  bit  idle_on = 1'b1;      // random idle bursts on both sides
  bit  hold_req = 1'b0;     // toggled to ask the receiver for a long hold-off
  bit  hold_seen = 1'b0;
  int  hold_left = 0;
  int  burst_left = 0;
  longint cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  buddy_block_allocator_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_tvalid (cfg_tvalid),
    .cfg_tready (cfg_tready),
    .cfg_tdata  (cfg_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // receiver: long hold-off on request, otherwise short random stalls
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen  <= hold_req;
      hold_left  <= 400;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (burst_left > 0) begin
      burst_left <= burst_left - 1;
      out_tready <= 1'b0;
    end else if (idle_on && rst_n && $urandom_range(0, 5) == 0) begin
      burst_left <= $urandom_range(0, 2);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_word(out_tuser, out_tdata);
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  // offer one word and hold it until taken; valid stays high for the next one
  task automatic send_word(logic op, logic [15:0] owner, logic [10:0] req,
                           logic [9:0] idx);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {3'b0, idx, req, owner};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_word(op, owner, req, idx);
  endtask

  task automatic stop_sending();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // block is idle once every result has come back
  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_pool_order(logic [3:0] ord);
    drain();
    cfg_tvalid <= 1'b1;
    cfg_tdata  <= {4'b0, ord};
    @(posedge clk);
    while (!cfg_tready) @(posedge clk);
    sb.restart(ord);
    cfg_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // random mix; well-formed requests dominate, with some that cannot fit
  task automatic random_words(int n);
    logic [15:0] owner;
    logic [10:0] req;
    logic [9:0]  idx;
    for (int j = 0; j < n; j++) begin
      if ($urandom_range(0, 9) < 6) begin
        owner = ($urandom_range(0, 9) == 0) ? 16'h0 : 16'($urandom);
        if ($urandom_range(0, 7) == 0) req = 11'($urandom_range(0, 1024));
        else req = 11'($urandom_range(0, 1 << sb.pool_ord));
        send_word(OP_ALLOC, owner, req, 10'($urandom));
      end else begin
        if ($urandom_range(0, 5) == 0) idx = 10'($urandom);
        else idx = 10'($urandom_range(0, sb.blk_total + 1));
        send_word(OP_READ, 16'($urandom), 11'($urandom_range(0, 2047) & 11'h7ff),
                  idx);
      end
    end
    stop_sending();
  endtask

  initial begin
    int phase_ord[9] = '{3, 5, 2, 7, 4, 10, 1, 6, 5};
    sb.restart(DEF_MAX_ORDER);
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset pool of order 10
    send_word(OP_ALLOC, 16'h0000, 11'd5, 10'd0);       // zero owner rejected
    send_word(OP_ALLOC, 16'hffff, 11'd0, 10'd0);       // zero request is one unit
    send_word(OP_READ,  16'h0, 11'd0, 10'd0);
    send_word(OP_READ,  16'h0, 11'd0, 10'd10);         // last block
    send_word(OP_READ,  16'h0, 11'd0, 10'd11);         // just past the end
    send_word(OP_READ,  16'h0, 11'd0, 10'd1023);
    send_word(OP_ALLOC, 16'h1234, 11'd1024, 10'd0);    // nothing that large is free
    send_word(OP_ALLOC, 16'h8001, 11'd512, 10'h3ff);
    send_word(OP_ALLOC, 16'h0001, 11'd3, 10'd0);
    send_word(OP_ALLOC, 16'h00aa, 11'd1000, 10'd0);
    send_word(OP_READ,  16'h0, 11'd0, 10'd2);
    stop_sending();
    // oversized order saturates to the largest pool
    write_pool_order(4'd15);
    send_word(OP_ALLOC, 16'h5555, 11'd1024, 10'd0);
    send_word(OP_ALLOC, 16'haaaa, 11'd1, 10'd0);       // pool fully taken
    send_word(OP_READ,  16'h0, 11'd0, 10'd0);
    send_word(OP_READ,  16'h0, 11'd0, 10'd1);
    stop_sending();
    // single-unit pool
    write_pool_order(4'd0);
    send_word(OP_ALLOC, 16'h0002, 11'd2, 10'd0);
    send_word(OP_ALLOC, 16'h0003, 11'd0, 10'd0);
    send_word(OP_ALLOC, 16'h0004, 11'd1, 10'd0);
    send_word(OP_READ,  16'h0, 11'd0, 10'd0);
    stop_sending();

    // random phases over several pool orders
    for (int p = 0; p < 9; p++) begin
      write_pool_order(4'(phase_ord[p]));
      if (p == 2) hold_req = ~hold_req;   // block fills up and stalls its input
      if (p == 8) idle_on = 1'b0;         // clean tail, no idling
      random_words(30);
    end

    drain();
    repeat (20) @(posedge clk);
    $display("covered %0d grants, %0d failed allocations, %0d reads, %0d bad indexes",
             sb.grants, sb.fails, sb.reads, sb.bad_reads);
    $display("pool orders 0 to 7 and 10 plus a saturating write, in %0d cycles", cycles);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
